[rtl/core/etd_pkg.sv]
// etd_pkg: types and constants shared by the event tag dedup cache
// holds the request and result structs, the front-to-back job type and the back fsm states
// no dependencies
`default_nettype none

package etd_pkg;

    localparam logic [31:0] HASH_SEED      = 32'd5381;
    localparam int unsigned HASH_SHIFT     = 5;
    localparam logic [31:0] COOLDOWN_RESET = 32'd1000;
    localparam int unsigned SLOT_W         = 3;
    localparam int unsigned QUEUE_DEPTH    = 2;

    typedef struct packed {
        logic [7:0]  tag_char;
        logic        last_char;
        logic [31:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic              duplicate;
        logic [31:0]       hash_value;
        logic [SLOT_W-1:0] slot;
        logic              new_entry;
    } out_item_t;

    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] time_ms;
    } job_t;

    typedef enum logic {
        BK_IDLE,
        BK_COMMIT
    } bk_state_t;

endpackage

`default_nettype wire

[rtl/core/etd_front.sv]
// etd_front: folds tag characters into the djb2 hash, one per cycle while the job queue is not full
// hands each complete tag's hash and time to the job queue; uses etd_pkg
`default_nettype none

module etd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic             queue_full,
    input  wire etd_pkg::in_item_t char_item,
    output logic                  job_push,
    output etd_pkg::job_t         job
);

    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic [31:0] folded;
    logic        accept;

    assign accept = push && !queue_full;
    assign folded = (hash_reg << etd_pkg::HASH_SHIFT) + hash_reg
                    + {24'd0, char_item.tag_char};

    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            if (char_item.last_char)
                hash_next = etd_pkg::HASH_SEED;
            else
                hash_next = folded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_reg <= etd_pkg::HASH_SEED;
        else
            hash_reg <= hash_next;
    end

    assign job_push    = accept && char_item.last_char;
    assign job.hash    = folded;
    assign job.time_ms = char_item.time_ms;

endmodule

`default_nettype wire

[rtl/core/etd_queue.sv]
// etd_queue: short job queue between the hashing front and the lookup back
// flop-based, QUEUE_DEPTH entries; uses etd_pkg
`default_nettype none

module etd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire etd_pkg::job_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output etd_pkg::job_t      rd_data,
    output logic               rd_valid
);

    localparam int unsigned DEPTH = etd_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    etd_pkg::job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

[rtl/core/etd_back.sv]
// etd_back: tag table lookup, cooldown check, table update and result register
// holds the cooldown register; uses etd_pkg
`default_nettype none

module etd_back #(
    parameter int unsigned TABLE_ENTRIES = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire etd_pkg::job_t job,
    output logic               job_pop,
    input  wire logic          cooldown_we,
    input  wire logic [31:0]   cooldown_wdata,
    input  wire logic          pop,
    output logic               empty,
    output etd_pkg::out_item_t result
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [31:0]            ent_hash_reg [TABLE_ENTRIES];
    logic [31:0]            ent_time_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] ent_valid_reg;
    logic [IDX_W-1:0]       ptr_reg;
    logic [31:0]            cooldown_reg;

    etd_pkg::bk_state_t     state_reg;
    etd_pkg::bk_state_t     state_next;

    logic                   lk_found_reg;
    logic [IDX_W-1:0]       lk_idx_reg;
    logic [31:0]            lk_hash_reg;
    logic [31:0]            lk_now_reg;
    logic [31:0]            lk_etime_reg;

    etd_pkg::out_item_t     res_reg;
    etd_pkg::out_item_t     res_next;
    logic                   res_valid_reg;

    logic                   match_found;
    logic [IDX_W-1:0]       match_idx;
    logic                   lookup_en;
    logic                   commit;
    logic [31:0]            elapsed;
    logic                   dup;
    logic [IDX_W-1:0]       commit_idx;
    logic [IDX_W+etd_pkg::SLOT_W-1:0] idx_ext;

    // first valid match in index order
    always_comb
    begin
        match_found = 1'b0;
        match_idx   = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (ent_valid_reg[i] && (ent_hash_reg[i] == job.hash))
            begin
                match_found = 1'b1;
                match_idx   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_pop    = 1'b0;
        lookup_en  = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            etd_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    lookup_en  = 1'b1;
                    state_next = etd_pkg::BK_COMMIT;
                end
            end
            etd_pkg::BK_COMMIT:
            begin
                if (!res_valid_reg || pop)
                begin
                    commit     = 1'b1;
                    state_next = etd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = etd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= etd_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (lookup_en)
        begin
            lk_found_reg <= match_found;
            lk_idx_reg   <= match_idx;
            lk_hash_reg  <= job.hash;
            lk_now_reg   <= job.time_ms;
            lk_etime_reg <= ent_time_reg[match_idx];
        end
    end

    assign elapsed    = lk_now_reg - lk_etime_reg;
    assign dup        = lk_found_reg && (elapsed < cooldown_reg);
    assign commit_idx = lk_found_reg ? lk_idx_reg : ptr_reg;
    assign idx_ext    = {{etd_pkg::SLOT_W{1'b0}}, commit_idx};

    always_comb
    begin
        res_next.duplicate  = dup;
        res_next.hash_value = lk_hash_reg;
        res_next.slot       = idx_ext[etd_pkg::SLOT_W-1:0];
        res_next.new_entry  = !lk_found_reg;
    end

    // table payload
    always_ff @(posedge clk)
    begin
        if (commit && !dup)
        begin
            ent_time_reg[commit_idx] <= lk_now_reg;
            if (!lk_found_reg)
                ent_hash_reg[commit_idx] <= lk_hash_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            ptr_reg       <= '0;
        end
        else if (commit && !lk_found_reg)
        begin
            ent_valid_reg[ptr_reg] <= 1'b1;
            ptr_reg <= (ptr_reg == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cooldown_reg <= etd_pkg::COOLDOWN_RESET;
        else if (cooldown_we)
            cooldown_reg <= cooldown_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (commit)
            res_valid_reg <= 1'b1;
        else if (pop)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            res_reg <= res_next;
    end

    assign empty  = !res_valid_reg;
    assign result = res_reg;

    a_new_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
        commit && !lk_found_reg |=> ent_valid_reg[$past(ptr_reg)])
        else $error("allocated entry not marked valid");

    a_new_not_dup: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.new_entry |-> !res_reg.duplicate)
        else $error("new entry reported as duplicate");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= IDX_W'(TABLE_ENTRIES - 1))
        else $error("replacement pointer out of range");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> !empty)
        else $error("committed result not presented");

endmodule

`default_nettype wire

[rtl/core/event_tag_dedup_cache.sv]
// event_tag_dedup_cache: top level of the djb2 hash and cooldown duplicate filter
// instantiates etd_front, etd_queue and etd_back; uses etd_pkg
// usage:
//   requests enter through a queue-style port: char_item is taken at an edge with
//   push high and full low, one tag character per request, last_char marking the
//   final character and time_ms sampled on it
//   results leave through a queue-style port: result is valid while empty is low and
//   is taken at an edge with pop high; one result per tag, none per inner character
//   cooldown_we writes cooldown_wdata into the cooldown register at once
// timing:
//   the front takes one character per cycle while full is low; the hash folds in
//   the same cycle; a complete tag passes a two-entry job queue to the back, which
//   works on one tag at a time (table compare, then cooldown check and table update)
//   and pops no new job until its result is committed; the final character passes
//   the job queue, the lookup registers and the result register before its result shows
// reset:
//   hash restarts at 5381, all table entries invalid, pointer and queue cleared,
//   cooldown returns to 1000
// stalls:
//   a held result stops the back, the job queue fills and full then holds off requests
`default_nettype none

module event_tag_dedup_cache #(
    parameter int unsigned TABLE_ENTRIES = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire etd_pkg::in_item_t char_item,
    input  wire logic              cooldown_we,
    input  wire logic [31:0]       cooldown_wdata,
    output logic                   empty,
    input  wire logic              pop,
    output etd_pkg::out_item_t     result
);

    logic          job_push;
    etd_pkg::job_t job_in;
    logic          job_valid;
    logic          job_pop;
    etd_pkg::job_t job_out;

    etd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .queue_full (full),
        .char_item  (char_item),
        .job_push   (job_push),
        .job        (job_in)
    );

    etd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_data  (job_in),
        .full     (full),
        .rd_en    (job_pop),
        .rd_data  (job_out),
        .rd_valid (job_valid)
    );

    etd_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (job_valid),
        .job            (job_out),
        .job_pop        (job_pop),
        .cooldown_we    (cooldown_we),
        .cooldown_wdata (cooldown_wdata),
        .pop            (pop),
        .empty          (empty),
        .result         (result)
    );

endmodule

`default_nettype wire

[bench/event_tag_dedup_cache_test.sv]
// event_tag_dedup_cache_test: self-checking bench for the djb2 tag dedup cache
// predicts hash, slot and cooldown verdict per tag, checks every result in order
// depends on etd_pkg and event_tag_dedup_cache
module event_tag_dedup_cache_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE  = 8;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 240;
    localparam int POOL_TAGS   = 12;
    localparam int MAX_TAG_LEN = 16;
    localparam int PRINT_LIMIT = 100;

    class dedup_predictor;
        logic [31:0] cooldown;
        logic [31:0] hash_acc;
        logic [31:0] entry_hash [TABLE_SIZE];
        logic [31:0] entry_time [TABLE_SIZE];
        bit          entry_valid [TABLE_SIZE];
        int unsigned replace_ptr;
        etd_pkg::out_item_t expected_verdicts [$];
        int          errors;

        function new();
            cooldown = etd_pkg::COOLDOWN_RESET;
            hash_acc = etd_pkg::HASH_SEED;
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                entry_hash[i]  = '0;
                entry_time[i]  = '0;
                entry_valid[i] = 1'b0;
            end
            replace_ptr = 0;
            errors      = 0;
        endfunction

        function void note_request(etd_pkg::in_item_t req);
            logic [31:0] h;
            logic [31:0] elapsed;
            int          hit;
            etd_pkg::out_item_t v;
            h = (hash_acc << etd_pkg::HASH_SHIFT) + hash_acc + 32'(req.tag_char);
            if (!req.last_char)
            begin
                hash_acc = h;
                return;
            end
            hash_acc = etd_pkg::HASH_SEED;
            hit = -1;
            for (int i = TABLE_SIZE - 1; i >= 0; i--)
                if (entry_valid[i] && entry_hash[i] == h)
                    hit = i;
            v.duplicate  = 1'b0;
            v.hash_value = h;
            v.new_entry  = 1'b0;
            if (hit >= 0)
            begin
                v.slot  = hit[etd_pkg::SLOT_W-1:0];
                elapsed = req.time_ms - entry_time[hit];
                if (elapsed < cooldown)
                    v.duplicate = 1'b1;
                else
                    entry_time[hit] = req.time_ms;
            end
            else
            begin
                v.slot                   = replace_ptr[etd_pkg::SLOT_W-1:0];
                entry_hash[replace_ptr]  = h;
                entry_time[replace_ptr]  = req.time_ms;
                entry_valid[replace_ptr] = 1'b1;
                replace_ptr              = (replace_ptr + 1) % TABLE_SIZE;
                v.new_entry              = 1'b1;
            end
            expected_verdicts.push_back(v);
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT)
                $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_verdict(etd_pkg::out_item_t got);
            etd_pkg::out_item_t want;
            if (expected_verdicts.size() == 0)
            begin
                report($sformatf("result with nothing pending, hash %h", got.hash_value));
                return;
            end
            want = expected_verdicts.pop_front();
            if (got.duplicate !== want.duplicate)
                report($sformatf("duplicate %b, want %b (hash %h)",
                                 got.duplicate, want.duplicate, want.hash_value));
            if (got.hash_value !== want.hash_value)
                report($sformatf("hash_value %h, want %h", got.hash_value, want.hash_value));
            if (got.slot !== want.slot)
                report($sformatf("slot %0d, want %0d (hash %h)",
                                 got.slot, want.slot, want.hash_value));
            if (got.new_entry !== want.new_entry)
                report($sformatf("new_entry %b, want %b (hash %h)",
                                 got.new_entry, want.new_entry, want.hash_value));
        endtask
    endclass

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        push           = 1'b0;
    logic        full;
    etd_pkg::in_item_t char_item = '0;
    logic        cooldown_we    = 1'b0;
    logic [31:0] cooldown_wdata = '0;
    logic        empty;
    logic        pop            = 1'b0;
    etd_pkg::out_item_t result;

    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    logic [31:0] clock_ms;
    dedup_predictor dedup;

    always #6 clk = ~clk;

    event_tag_dedup_cache #(
        .TABLE_ENTRIES(TABLE_SIZE)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_item     (char_item),
        .cooldown_we   (cooldown_we),
        .cooldown_wdata(cooldown_wdata),
        .empty         (empty),
        .pop           (pop),
        .result        (result)
    );

    task automatic send_char(logic [7:0] c, bit last, logic [31:0] t);
        etd_pkg::in_item_t req;
        req.tag_char  = c;
        req.last_char = last;
        req.time_ms   = t;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        char_item <= req;
        do
            @(posedge clk);
        while (full !== 1'b0);
        dedup.note_request(req);
    endtask

    task automatic wait_results();
        push <= 1'b0;
        while (dedup.expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cooldown(logic [31:0] value);
        wait_results();
        repeat (8) @(posedge clk);
        cooldown_we    <= 1'b1;
        cooldown_wdata <= value;
        @(posedge clk);
        cooldown_we    <= 1'b0;
        dedup.cooldown = value;
    endtask

    function automatic logic [31:0] next_gap(logic [31:0] cd);
        case ($urandom_range(0, 6))
            0:       return 32'd0;
            1:       return $urandom_range(0, 3);
            2:       return $urandom_range(0, 64);
            3:       return (cd >> 2) + $urandom_range(0, 7);
            4:       return cd - $urandom_range(0, 2);
            5:       return cd + $urandom_range(0, 2);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_directed();
        logic [7:0]  singles [8];
        logic [31:0] t0;
        singles = '{8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h02, 8'h03};
        t0 = 32'hFFFF_FF00;
        // cooldown edges across the time wrap
        send_char(8'h41, 1'b1, t0);
        send_char(8'h41, 1'b1, t0 + 32'd999);
        send_char(8'h41, 1'b1, t0 + 32'd1000);
        send_char(8'h41, 1'b1, t0 + 32'd1000);
        // zero character folds in, tag ends only on last_char
        send_char(8'h00, 1'b0, $urandom);
        send_char(8'hFF, 1'b1, 32'h0);
        // fill the table and wrap the replacement pointer
        foreach (singles[i])
            send_char(singles[i], 1'b1, 32'h0000_1000);
        send_char(8'h41, 1'b1, 32'hFFFF_FFFF);
        for (int j = 0; j < 4; j++)
            send_char(8'hFF, j == 3, (j == 3) ? 32'h8000_0000 : $urandom);
    endtask

    task automatic run_phase(int n_items);
        logic [7:0] pool [POOL_TAGS][MAX_TAG_LEN];
        int         pool_len [POOL_TAGS];
        logic [7:0] tag [MAX_TAG_LEN];
        int         len;
        int         sent;
        int         pick;
        bit         paused;
        sent   = 0;
        paused = 1'b0;
        for (int i = 0; i < POOL_TAGS; i++)
        begin
            pool_len[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(6, MAX_TAG_LEN)
                                                       : $urandom_range(1, 4);
            for (int j = 0; j < MAX_TAG_LEN; j++)
                pool[i][j] = 8'($urandom_range(1, 255));
        end
        while (sent < n_items)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                len = $urandom_range(1, 6);
                for (int j = 0; j < len; j++)
                    tag[j] = 8'($urandom_range(1, 255));
            end
            else
            begin
                // a few hot tags so repeats hit the cooldown often
                pick = $urandom_range(0, 1) ? $urandom_range(0, 2)
                                            : $urandom_range(0, POOL_TAGS - 1);
                len  = pool_len[pick];
                for (int j = 0; j < len; j++)
                    tag[j] = pool[pick][j];
            end
            clock_ms += next_gap(dedup.cooldown);
            for (int j = 0; j < len; j++)
                send_char(tag[j], j == len - 1, (j == len - 1) ? clock_ms : $urandom);
            sent += len;
            if ((!paused && sent >= n_items / 2) || $urandom_range(0, 99) == 0)
            begin
                wait_results();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        logic [31:0] phase_cooldowns [PHASES];
        dedup    = new();
        clock_ms = $urandom;
        phase_cooldowns = '{32'd0, 32'hFFFF_FFFF, 32'd100, 32'd1, 32'd5000, 32'd0};
        phase_cooldowns[PHASES - 1] = $urandom_range(10, 3000);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int p = 0; p < PHASES; p++)
        begin
            write_cooldown(phase_cooldowns[p]);
            case (p % 3)
                0:
                begin
                    send_idle_pct = 22;
                    recv_idle_pct = 52;
                end
                1:
                begin
                    send_idle_pct = 52;
                    recv_idle_pct = 22;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            run_phase(PHASE_ITEMS);
        end
        wait_results();
        repeat (20) @(posedge clk);
        if (dedup.errors == 0)
            $display("event_tag_dedup_cache verification clean");
        else
            $display("event_tag_dedup_cache verification failed");
        $finish;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && empty === 1'b0)
                dedup.check_verdict(result);
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #5ms;
        $display("event_tag_dedup_cache verification failed");
        $finish;
    end

endmodule
